>>> src/bfe_pkg.sv
// Shared constants, types and offset decode for the battery frame extractor.
package bfe_pkg;

    localparam int unsigned FRAME_LEN  = 14;
    localparam int unsigned HDR_LEN    = 5;
    localparam int unsigned SLOT_COUNT = 8;   // stored payload slots; the final byte bypasses

    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'h2B;
    localparam logic [7:0] HDR2 = 8'h04;
    localparam logic [7:0] HDR3 = 8'h58;
    localparam logic [7:0] HDR4 = 8'h05;

    localparam logic [31:0] HDR_PREFIX  = {HDR0, HDR1, HDR2, HDR3};
    localparam logic [4:0]  OFF_HDR_END = 5'd4;
    localparam logic [4:0]  OFF_LAST    = 5'd31;
    localparam logic [4:0]  OFF_PRE_LAST = 5'd30;
    localparam logic [3:0]  IDX_LAST    = 4'(FRAME_LEN - 1);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } slot_t;

    // Map a frame offset to its payload slot.
    function automatic slot_t slot_of(input logic [4:0] off);
        slot_t s;
        s.hit = 1'b1;
        s.idx = 3'd0;
        case (off)
            5'd12: s.idx = 3'd0;
            5'd13: s.idx = 3'd1;
            5'd20: s.idx = 3'd2;
            5'd21: s.idx = 3'd3;
            5'd24: s.idx = 3'd4;
            5'd25: s.idx = 3'd5;
            5'd28: s.idx = 3'd6;
            5'd29: s.idx = 3'd7;
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

>>> src/battery_frame_extractor.sv
// Battery frame extractor: header search, payload capture and 14-beat frame emission.
// Latency: the first frame beat is presented the cycle after the byte at offset 31 is taken.
// Throughput: one input byte per cycle; a frame drains as 14 beats, one per cycle when m_tready
//   stays high. Input stalls only while a frame is draining and the next byte would end another.
// Reset (aresetn low, synchronous): clears the header window, the capture state, the frame
//   offset, the beat index and the output valid. Payload and frame buffers are not reset.
module battery_frame_extractor
    import bfe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // burst_end
    // frame stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // frame_last
);

    // search and capture state
    logic [31:0] window_reg;
    logic        capturing_reg;
    logic [4:0]  offset_reg;
    byte_t       slot_reg [SLOT_COUNT];

    // emission state: the completed frame is copied here so a new frame can fill slot_reg
    byte_t       frame_reg [FRAME_LEN];
    logic        busy_reg;
    logic [3:0]  idx_reg;

    logic        s_fire;
    logic        m_fire;
    logic [4:0]  offset_next;
    slot_t       slot;
    logic        frame_done;
    logic        hdr_hit;

    // Hold off input only when the next byte would complete a frame while one still drains.
    assign s_tready = !(busy_reg && capturing_reg && (offset_reg == OFF_PRE_LAST));
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = busy_reg && m_tready;

    assign offset_next = offset_reg + 5'd1;
    assign slot        = slot_of(offset_next);
    assign frame_done  = capturing_reg && (offset_next == OFF_LAST);
    assign hdr_hit     = !capturing_reg && !s_tlast && (s_tdata == HDR4)
                         && (window_reg == HDR_PREFIX);

    // Control state: header window, capture flag and frame offset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            capturing_reg <= 1'b0;
            offset_reg    <= '0;
        end else if (s_fire) begin
            if (capturing_reg) begin
                window_reg <= '0;
                if (frame_done || s_tlast) begin
                    // complete frame, or drop a frame cut short by the burst end
                    capturing_reg <= 1'b0;
                    offset_reg    <= '0;
                end else begin
                    offset_reg <= offset_next;
                end
            end else if (hdr_hit) begin
                capturing_reg <= 1'b1;
                offset_reg    <= OFF_HDR_END;
                window_reg    <= '0;
            end else if (s_tlast) begin
                window_reg <= '0;   // a header never spans two bursts
            end else begin
                window_reg <= {window_reg[23:0], s_tdata};
            end
        end
    end

    // Payload capture and frame copy.
    always_ff @(posedge aclk) begin
        if (s_fire && capturing_reg && slot.hit) begin
            slot_reg[slot.idx] <= s_tdata;
        end
        if (s_fire && frame_done) begin
            frame_reg[0] <= HDR0;
            frame_reg[1] <= HDR1;
            frame_reg[2] <= HDR2;
            frame_reg[3] <= HDR3;
            frame_reg[4] <= HDR4;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                frame_reg[HDR_LEN + k] <= slot_reg[k];
            end
            frame_reg[FRAME_LEN - 1] <= s_tdata;
        end
    end

    // Emission counter: advance one beat per handshake, release after the last.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (s_fire && frame_done) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (m_fire) begin
            if (idx_reg == IDX_LAST) begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end else begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = frame_reg[idx_reg];
    assign m_tlast  = (idx_reg == IDX_LAST);

    // A stalled input always means a frame is draining.
    a_stall_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> busy_reg)
        else $error("input stalled with no frame draining");

    // The beat index never runs past the last frame byte.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= IDX_LAST))
        else $error("frame beat index out of range");

    // The header window stays clear for the whole frame.
    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> (window_reg == '0))
        else $error("header window not clear while capturing");

    // While capturing, the offset lies between the header end and the byte before the last.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> ((offset_reg >= OFF_HDR_END) && (offset_reg <= OFF_PRE_LAST)))
        else $error("frame offset out of range");

    // A completed frame starts draining from its first byte.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && frame_done) |=> (busy_reg && (idx_reg == '0) && !capturing_reg))
        else $error("frame did not start emission");

endmodule
